// ===== hdl/bpl_pkg.sv =====
// Shared types and constants for the bounded positional list.
`default_nettype none

package bpl_pkg;

    localparam int LEN_W    = 5;   // element count and capacity width
    localparam int VAL_W    = 32;  // element width
    localparam int ACT_W    = 3;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;

    localparam int S_TDATA_W = 48; // 42 bits of fields, padded to bytes
    localparam int M_TDATA_W = 40; // 39 bits of fields, padded to bytes

    localparam logic [LEN_W-1:0] CAP_RESET = 5'd16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_END   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_END   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_POS   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_LIST      = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/bounded_positional_list.sv =====
// Bounded positional list: ordered list of signed 32-bit values in one RAM.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready     | action, element_value, position
//  m_axis   | out | m_axis_tvalid/tready     | status, item_value, list_length; tlast
//  cfg      | in  | cfg_wr_en (no wait)      | capacity_limit
//
// Shifting: an insert or delete moves the elements behind its index one at a time,
//   then finishes; a rejected or no-op action goes straight to the finish step, and a
//   listing reads and emits one element at a time. Each moved element costs one RAM
//   read and one RAM write, since the list RAM has one read and one write port, read
//   data registered.
// Reset: element count clears to zero, capacity to 16. The RAM is not cleared;
//   only entries below the count are ever read.
// Stalls: s_axis_tready is high only while idle. One output register holds a
//   finished result; the block waits in its finish or emit step while that is full.
`default_nettype none

module bounded_positional_list
    import bpl_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] action, [34:3] element_value, [41:35] position, [47:42] zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [1:0] status, [33:2] item_value, [38:34] list_length, [39] zero
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    output logic                       m_axis_tlast,   // last_item

    input  wire logic                  cfg_wr_en,
    input  wire logic [LEN_W-1:0]      cfg_wr_data     // capacity_limit
);

    // AW: RAM address width; PW: pointer width, holds the count and the depth
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DW = $clog2(LIST_DEPTH + 1);
    localparam int PW = (DW > LEN_W) ? DW : LEN_W;
    localparam logic [PW-1:0] DEPTH_V = PW'(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,   // read the element to move
        S_SH_WR,   // write it one place over
        S_FIN,     // update count, place new value, emit result
        S_L_RD,    // read next element for listing
        S_L_EMIT   // emit it
    } state_t;

    state_t                 state_reg;
    logic [LEN_W-1:0]       cnt_reg;
    logic [LEN_W-1:0]       cap_reg;
    logic [PW-1:0]          ptr_reg;
    logic [PW-1:0]          idx_reg;
    logic [VAL_W-1:0]       value_reg;
    logic                   ins_reg;
    logic                   del_reg;
    logic [STAT_W-1:0]      stat_reg;

    logic                   m_valid_reg;
    logic [STAT_W-1:0]      m_status_reg;
    logic [VAL_W-1:0]       m_item_reg;
    logic                   m_last_reg;
    logic [LEN_W-1:0]       m_len_reg;

    // list RAM
    logic [VAL_W-1:0]       mem [LIST_DEPTH];
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VAL_W-1:0]       wr_data;

    // input fields
    logic [ACT_W-1:0]       in_action;
    logic [VAL_W-1:0]       in_value;
    logic [POS_W-1:0]       in_pos;

    // decode of the incoming action
    logic                   full;
    logic                   empty;
    logic [PW-1:0]          cnt_ext;
    logic [POS_W:0]         pos_ext;
    logic [POS_W:0]         cnt_pos;
    logic [PW-1:0]          pos_idx;
    logic [STAT_W-1:0]      dec_status;
    logic                   dec_ins;
    logic                   dec_del;
    logic                   dec_list;
    logic [PW-1:0]          dec_idx;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic [PW-1:0]          dst_ptr;
    logic                   list_last;

    assign in_action = s_axis_tdata[2:0];
    assign in_value  = s_axis_tdata[34:3];
    assign in_pos    = s_axis_tdata[41:35];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    // a new result goes into the output register this cycle
    assign out_load      = out_free && ((state_reg == S_FIN) || (state_reg == S_L_EMIT));

    assign cnt_ext  = PW'(cnt_reg);
    assign pos_ext  = {1'b0, in_pos};
    assign cnt_pos  = (POS_W + 1)'(cnt_reg);
    assign pos_idx  = PW'(in_pos - POS_W'(1));
    // effective capacity is min(capacity_limit, LIST_DEPTH)
    assign full     = (cnt_ext >= PW'(cap_reg)) || (cnt_ext >= DEPTH_V);
    assign empty    = (cnt_reg == '0);

    always_comb
    begin
        dec_status = ST_OK;
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_list   = 1'b0;
        dec_idx    = '0;
        unique case (in_action)
            ACT_INS_FRONT:
            begin
                if (full) dec_status = ST_FULL;
                else      dec_ins    = 1'b1;
            end
            ACT_INS_END:
            begin
                if (full)
                    dec_status = ST_FULL;
                else
                begin
                    dec_ins = 1'b1;
                    dec_idx = cnt_ext;
                end
            end
            ACT_INS_POS:
            begin
                priority if (full)
                    dec_status = ST_FULL;
                else if (in_pos <= POS_W'(1))
                    dec_ins = 1'b1;
                else if (pos_ext > cnt_pos + (POS_W + 1)'(1))
                    dec_status = ST_RANGE;
                else
                begin
                    dec_ins = 1'b1;
                    dec_idx = pos_idx;
                end
            end
            ACT_DEL_FRONT:
            begin
                if (empty) dec_status = ST_EMPTY;
                else       dec_del    = 1'b1;
            end
            ACT_DEL_END:
            begin
                if (empty)
                    dec_status = ST_EMPTY;
                else
                begin
                    dec_del = 1'b1;
                    dec_idx = cnt_ext - PW'(1);
                end
            end
            ACT_DEL_POS:
            begin
                priority if (empty)
                    dec_status = ST_EMPTY;
                else if (in_pos == '0 || pos_ext > cnt_pos)
                    dec_status = ST_RANGE;
                else
                begin
                    dec_del = 1'b1;
                    dec_idx = pos_idx;
                end
            end
            ACT_LIST:
            begin
                if (empty) dec_status = ST_EMPTY;
                else       dec_list   = 1'b1;
            end
            default:
            begin
                dec_status = ST_OK;   // unused code: no change, one result
            end
        endcase
    end

    // shift direction: insert moves elements back, delete moves them forward
    assign dst_ptr   = ins_reg ? (ptr_reg + PW'(1)) : (ptr_reg - PW'(1));
    assign list_last = (ptr_reg == cnt_ext - PW'(1));

    assign rd_en   = (state_reg == S_SH_RD) || (state_reg == S_L_RD);
    assign rd_addr = ptr_reg[AW-1:0];
    assign wr_en   = (state_reg == S_SH_WR) ||
                     ((state_reg == S_FIN) && out_free && ins_reg);
    assign wr_addr = (state_reg == S_SH_WR) ? dst_ptr[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data = (state_reg == S_SH_WR) ? rd_data_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            cap_reg      <= CAP_RESET;
            ptr_reg      <= '0;
            idx_reg      <= '0;
            value_reg    <= '0;
            ins_reg      <= 1'b0;
            del_reg      <= 1'b0;
            stat_reg     <= ST_OK;
            m_valid_reg  <= 1'b0;
            m_status_reg <= ST_OK;
            m_item_reg   <= '0;
            m_last_reg   <= 1'b0;
            m_len_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;

            if (m_valid_reg && m_axis_tready && !out_load)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        value_reg <= in_value;
                        idx_reg   <= dec_idx;
                        ins_reg   <= dec_ins;
                        del_reg   <= dec_del;
                        stat_reg  <= dec_status;
                        priority if (dec_list)
                        begin
                            ptr_reg   <= '0;
                            state_reg <= S_L_RD;
                        end
                        else if (dec_ins && cnt_ext > dec_idx)
                        begin
                            ptr_reg   <= cnt_ext - PW'(1);
                            state_reg <= S_SH_RD;
                        end
                        else if (dec_del && (dec_idx + PW'(1)) < cnt_ext)
                        begin
                            ptr_reg   <= dec_idx + PW'(1);
                            state_reg <= S_SH_RD;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    priority if (ins_reg && ptr_reg == idx_reg)
                        state_reg <= S_FIN;
                    else if (!ins_reg && ptr_reg == cnt_ext - PW'(1))
                        state_reg <= S_FIN;
                    else
                    begin
                        ptr_reg   <= ins_reg ? (ptr_reg - PW'(1)) : (ptr_reg + PW'(1));
                        state_reg <= S_SH_RD;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= stat_reg;
                        m_item_reg   <= '0;
                        m_last_reg   <= 1'b1;
                        priority if (ins_reg)
                        begin
                            cnt_reg   <= cnt_reg + LEN_W'(1);
                            m_len_reg <= cnt_reg + LEN_W'(1);
                        end
                        else if (del_reg)
                        begin
                            cnt_reg   <= cnt_reg - LEN_W'(1);
                            m_len_reg <= cnt_reg - LEN_W'(1);
                        end
                        else
                            m_len_reg <= cnt_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_L_RD:
                begin
                    state_reg <= S_L_EMIT;
                end
                S_L_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= ST_OK;
                        m_item_reg   <= rd_data_reg;
                        m_last_reg   <= list_last;
                        m_len_reg    <= cnt_reg;
                        if (list_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            ptr_reg   <= ptr_reg + PW'(1);
                            state_reg <= S_L_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {1'b0, m_len_reg, m_item_reg, m_status_reg};

`ifndef SYNTHESIS
    // count never goes past the RAM depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= DEPTH_V)
        else $error("element count exceeds list depth");

    // count moves only in the finish step
    a_cnt_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FIN) |=> (cnt_reg == $past(cnt_reg)))
        else $error("element count changed outside finish step");

    // count moves by at most one per action
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + LEN_W'(1)) ||
        (cnt_reg == $past(cnt_reg) - LEN_W'(1)))
        else $error("element count jumped");

    // RAM reads stay inside the occupied part of the list
    a_rd_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (ptr_reg < cnt_ext))
        else $error("read beyond end of list");

    // a result is loaded only when the output register has room
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready && (state_reg == S_FIN || state_reg == S_L_EMIT))
        |=> (state_reg == $past(state_reg)))
        else $error("result loaded while output register full");
`endif

endmodule

`default_nettype wire
